// ===== rtl/qs_pkg.sv =====
// shared sizes for the quicksort engine
`default_nettype none

package qs_pkg;

  localparam int MaxElems = 64;
  localparam int IdxW     = $clog2(MaxElems);
  localparam int CntW     = IdxW + 1;
  localparam int PtrW     = IdxW + 2;
  localparam int ValW     = 32;
  localparam int RangeW   = 2 * IdxW;

endpackage

`default_nettype wire

// ===== rtl/qs_in_if.sv =====
// element input channel of the quicksort engine
`default_nettype none

interface qs_in_if import qs_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [ValW-1:0] elem_value;
  logic                   elem_last;

  modport source(output valid, output elem_value, output elem_last, input ready);
  modport sink(input valid, input elem_value, input elem_last, output ready);
endinterface

`default_nettype wire

// ===== rtl/qs_out_if.sv =====
// sorted result channel of the quicksort engine
`default_nettype none

interface qs_out_if import qs_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [ValW-1:0] sorted_value;
  logic                   sorted_last;
  logic                   overflowed;

  modport source(output valid, output sorted_value, output sorted_last, output overflowed,
                 input ready);
  modport sink(input valid, input sorted_value, input sorted_last, input overflowed,
               output ready);
endinterface

`default_nettype wire

// ===== rtl/quicksort_engine.sv =====
// quicksort engine top level: load, in-place sort and ordered readout of a set
`default_nettype none

// Elements arrive one beat each on elem_i and are written into a 64-entry
// element ram, one cycle per beat. A beat with elem_last set ends the set
// (beats that find the ram full are dropped and remembered as overflow; a
// dropped last beat still ends the set). The engine then sorts the ram in
// place by quicksort with the first element of each range as pivot, keeping
// pending ranges on a stack held in a second small ram. All compares go
// through the single read port of the element ram and all swaps through its
// single write port; already ordered input is a worst case. Results then
// leave on sorted_o in ascending order, one beat at a time, the next being
// read only after the previous beat has been taken, with sorted_last on the
// final beat and overflowed on every beat. elem_i is not ready from the last
// beat of a set until the final result beat of that set has been taken.
// After reset no clearing pass is run.
module quicksort_engine import qs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  qs_in_if.sink     elem_i,
  qs_out_if.source  sorted_o
);

  typedef enum logic [4:0] {
    S_LOAD,
    S_INIT,
    S_POP,
    S_POP_WAIT,
    S_PIV_WAIT,
    S_F_CHK,
    S_F_WAIT,
    S_R_CHK,
    S_R_WAIT,
    S_SWAP_CHK,
    S_SWAP2,
    S_FIN,
    S_FIN_WAIT,
    S_FIN2,
    S_PUSH1,
    S_PUSH2,
    S_EMIT_RD,
    S_EMIT_WAIT,
    S_EMIT_HOLD
  } state_e;

  state_e state_q;

  // element count, overflow flag and range stack pointer
  logic [CntW-1:0] cnt_q;
  logic            ovf_q;
  logic [CntW-1:0] sp_q;

  // current range and scan pointers (signed, the backward one can pass below start)
  logic [IdxW-1:0]        s_q, e_q;
  logic signed [PtrW-1:0] f_q, r_q;
  logic signed [ValW-1:0] pivot_q;
  logic signed [ValW-1:0] val_f_q, val_r_q;

  // readout index
  logic [CntW-1:0] k_q;

  // output register
  logic                   out_valid_q;
  logic signed [ValW-1:0] out_value_q;
  logic                   out_last_q;
  logic                   out_ovf_q;

  // element ram port
  logic                   st_we;
  logic [IdxW-1:0]        st_waddr, st_raddr;
  logic [ValW-1:0]        st_wdata, st_rdata;
  logic signed [ValW-1:0] st_rval;

  // range stack ram port
  logic                   sk_we;
  logic [IdxW-1:0]        sk_waddr, sk_raddr;
  logic [RangeW-1:0]      sk_wdata, sk_rdata;

  qs_ram #(.Width(ValW), .Depth(MaxElems)) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  qs_ram #(.Width(RangeW), .Depth(MaxElems)) u_stack (
    .clk_i   (clk_i),
    .we_i    (sk_we),
    .waddr_i (sk_waddr),
    .wdata_i (sk_wdata),
    .raddr_i (sk_raddr),
    .rdata_o (sk_rdata)
  );

  assign st_rval = signed'(st_rdata);

  // derived values
  logic                   in_beat;
  logic                   store_full;
  logic                   stack_full;
  logic [CntW-1:0]        sp_dec;
  logic [IdxW-1:0]        pop_s, pop_e;
  logic signed [PtrW-1:0] s_s, e_s;
  logic signed [PtrW-1:0] r_fix, r_m1, r_p1;
  logic                   f_go, r_go;
  logic                   push_lo, push_hi;
  logic                   emit_last;

  assign in_beat    = elem_i.valid && elem_i.ready;
  assign store_full = (cnt_q == CntW'(MaxElems));
  assign stack_full = (sp_q == CntW'(MaxElems));
  assign sp_dec     = sp_q - CntW'(1);
  assign pop_s      = sk_rdata[RangeW-1:IdxW];
  assign pop_e      = sk_rdata[IdxW-1:0];
  assign s_s        = signed'({2'b00, s_q});
  assign e_s        = signed'({2'b00, e_q});
  assign r_fix      = (r_q < s_s) ? s_s : r_q;
  assign r_m1       = r_q - PtrW'(1);
  assign r_p1       = r_q + PtrW'(1);
  // forward scan continues while inside the range and short of the backward pointer
  assign f_go       = (f_q <= e_s) && (r_q > f_q);
  // backward scan continues while not below the range start or the forward pointer
  assign r_go       = (r_q >= s_s) && (r_q >= f_q);
  assign push_lo    = (r_m1 > s_s);
  assign push_hi    = (e_s > r_p1);
  assign emit_last  = ((k_q + CntW'(1)) == cnt_q);

  assign elem_i.ready          = (state_q == S_LOAD);
  assign sorted_o.valid        = out_valid_q;
  assign sorted_o.sorted_value = out_value_q;
  assign sorted_o.sorted_last  = out_last_q;
  assign sorted_o.overflowed   = out_ovf_q;

  // index of the last stored element
  function automatic logic [IdxW-1:0] sp_dec_cnt(input logic [CntW-1:0] cnt);
    logic [CntW-1:0] last_idx;
    last_idx = cnt - CntW'(1);
    return last_idx[IdxW-1:0];
  endfunction

  // ram address and write steering per sequencer step
  always_comb begin
    st_we    = 1'b0;
    st_waddr = '0;
    st_wdata = '0;
    st_raddr = '0;
    sk_we    = 1'b0;
    sk_waddr = '0;
    sk_wdata = '0;
    sk_raddr = '0;
    case (state_q)
      S_LOAD: begin
        st_we    = in_beat && !store_full;
        st_waddr = cnt_q[IdxW-1:0];
        st_wdata = elem_i.elem_value;
      end
      S_INIT: begin
        // whole set becomes the first range
        sk_we    = (cnt_q > CntW'(1));
        sk_waddr = '0;
        sk_wdata = {IdxW'(0), sp_dec_cnt(cnt_q)};
      end
      S_POP: begin
        sk_raddr = sp_dec[IdxW-1:0];
      end
      S_POP_WAIT: begin
        st_raddr = pop_s;
      end
      S_F_CHK: begin
        st_raddr = f_q[IdxW-1:0];
      end
      S_R_CHK: begin
        st_raddr = r_q[IdxW-1:0];
      end
      S_SWAP_CHK: begin
        st_we    = (r_q > f_q);
        st_waddr = f_q[IdxW-1:0];
        st_wdata = val_r_q;
      end
      S_SWAP2: begin
        st_we    = 1'b1;
        st_waddr = r_q[IdxW-1:0];
        st_wdata = val_f_q;
      end
      S_FIN: begin
        st_raddr = r_fix[IdxW-1:0];
      end
      S_FIN_WAIT: begin
        // pivot slot takes the element from the split point
        st_we    = 1'b1;
        st_waddr = s_q;
        st_wdata = st_rdata;
      end
      S_FIN2: begin
        st_we    = 1'b1;
        st_waddr = r_q[IdxW-1:0];
        st_wdata = pivot_q;
      end
      S_PUSH1: begin
        sk_we    = push_lo && !stack_full;
        sk_waddr = sp_q[IdxW-1:0];
        sk_wdata = {s_q, r_m1[IdxW-1:0]};
      end
      S_PUSH2: begin
        sk_we    = push_hi && !stack_full;
        sk_waddr = sp_q[IdxW-1:0];
        sk_wdata = {r_p1[IdxW-1:0], e_q};
      end
      S_EMIT_RD: begin
        st_raddr = k_q[IdxW-1:0];
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      sp_q        <= '0;
      s_q         <= '0;
      e_q         <= '0;
      f_q         <= '0;
      r_q         <= '0;
      pivot_q     <= '0;
      val_f_q     <= '0;
      val_r_q     <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
      out_value_q <= '0;
      out_last_q  <= 1'b0;
      out_ovf_q   <= 1'b0;
    end else begin
      case (state_q)
        S_LOAD: begin
          if (in_beat) begin
            if (store_full) begin
              ovf_q <= 1'b1;
            end else begin
              cnt_q <= cnt_q + CntW'(1);
            end
            if (elem_i.elem_last) begin
              state_q <= S_INIT;
            end
          end
        end
        S_INIT: begin
          sp_q    <= (cnt_q > CntW'(1)) ? CntW'(1) : CntW'(0);
          state_q <= S_POP;
        end
        S_POP: begin
          if (sp_q == '0) begin
            k_q     <= '0;
            state_q <= S_EMIT_RD;
          end else begin
            sp_q    <= sp_dec;
            state_q <= S_POP_WAIT;
          end
        end
        S_POP_WAIT: begin
          s_q <= pop_s;
          e_q <= pop_e;
          f_q <= signed'({2'b00, pop_s});
          r_q <= signed'({2'b00, pop_e});
          // ranges outside the set or shorter than two are skipped
          if (({1'b0, pop_e} >= cnt_q) || (pop_s >= pop_e)) begin
            state_q <= S_POP;
          end else begin
            state_q <= S_PIV_WAIT;
          end
        end
        S_PIV_WAIT: begin
          pivot_q <= st_rval;
          state_q <= S_F_CHK;
        end
        S_F_CHK: begin
          state_q <= f_go ? S_F_WAIT : S_R_CHK;
        end
        S_F_WAIT: begin
          if (st_rval <= pivot_q) begin
            f_q     <= f_q + PtrW'(1);
            state_q <= S_F_CHK;
          end else begin
            val_f_q <= st_rval;
            state_q <= S_R_CHK;
          end
        end
        S_R_CHK: begin
          state_q <= r_go ? S_R_WAIT : S_SWAP_CHK;
        end
        S_R_WAIT: begin
          if (st_rval > pivot_q) begin
            r_q     <= r_m1;
            state_q <= S_R_CHK;
          end else begin
            val_r_q <= st_rval;
            state_q <= S_SWAP_CHK;
          end
        end
        S_SWAP_CHK: begin
          state_q <= (r_q > f_q) ? S_SWAP2 : S_FIN;
        end
        S_SWAP2: begin
          state_q <= S_F_CHK;
        end
        S_FIN: begin
          r_q     <= r_fix;
          state_q <= S_FIN_WAIT;
        end
        S_FIN_WAIT: begin
          state_q <= S_FIN2;
        end
        S_FIN2: begin
          state_q <= S_PUSH1;
        end
        S_PUSH1: begin
          if (push_lo && !stack_full) begin
            sp_q <= sp_q + CntW'(1);
          end
          state_q <= S_PUSH2;
        end
        S_PUSH2: begin
          if (push_hi && !stack_full) begin
            sp_q <= sp_q + CntW'(1);
          end
          state_q <= S_POP;
        end
        S_EMIT_RD: begin
          state_q <= S_EMIT_WAIT;
        end
        S_EMIT_WAIT: begin
          out_valid_q <= 1'b1;
          out_value_q <= st_rval;
          out_last_q  <= emit_last;
          out_ovf_q   <= ovf_q;
          state_q     <= S_EMIT_HOLD;
        end
        S_EMIT_HOLD: begin
          if (sorted_o.ready) begin
            out_valid_q <= 1'b0;
            if (emit_last) begin
              // set done, back to loading
              cnt_q   <= '0;
              ovf_q   <= 1'b0;
              state_q <= S_LOAD;
            end else begin
              k_q     <= k_q + CntW'(1);
              state_q <= S_EMIT_RD;
            end
          end
        end
        default: begin
          state_q <= S_LOAD;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/qs_ram.sv =====
// generic single write port, single read port ram with registered read
`default_nettype none

module qs_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== test/sort_checker.sv =====
// checker for the quicksort engine: watches both channels, predicts and compares sorted beats
`default_nettype none

module sort_checker import qs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  qs_in_if     elem_i,
  qs_out_if    sorted_i,
  output int   fail_count_o,
  output int   expected_left_o,
  output int   checked_o
);

  typedef struct packed {
    logic signed [ValW-1:0] value;
    logic                   is_last;
    logic                   ovf;
  } sorted_beat_t;

  // set being loaded, kept in ascending order as beats arrive
  logic signed [ValW-1:0] loaded_q[$];
  int                     loaded_count;
  logic                   dropped_seen;
  sorted_beat_t           sorted_expect_q[$];

  initial begin
    fail_count_o    = 0;
    expected_left_o = 0;
    checked_o       = 0;
    loaded_count    = 0;
    dropped_seen    = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] sorted_o mismatch: %s", $time, msg);
    fail_count_o++;
  endtask

  task automatic load_element(input logic signed [ValW-1:0] v, input logic is_last);
    int           pos;
    sorted_beat_t beat;
    if (loaded_count < MaxElems) begin
      pos = 0;
      while (pos < loaded_q.size() && loaded_q[pos] <= v) pos++;
      loaded_q.insert(pos, v);
      loaded_count++;
    end else begin
      // store full: beat dropped, the last one still closes the set
      dropped_seen = 1'b1;
    end
    if (is_last) begin
      foreach (loaded_q[k]) begin
        beat.value   = loaded_q[k];
        beat.is_last = (k == loaded_q.size() - 1);
        beat.ovf     = dropped_seen;
        sorted_expect_q.push_back(beat);
      end
      loaded_q.delete();
      loaded_count = 0;
      dropped_seen = 1'b0;
    end
  endtask

  task automatic compare_sorted(input sorted_beat_t got);
    sorted_beat_t want;
    if (sorted_expect_q.size() == 0) begin
      report_mismatch($sformatf("unexpected beat, value %0d", got.value));
      return;
    end
    want = sorted_expect_q.pop_front();
    checked_o++;
    if (got.value !== want.value)
      report_mismatch($sformatf("sorted_value %0d, expected %0d", got.value, want.value));
    if (got.is_last !== want.is_last)
      report_mismatch($sformatf("sorted_last %b, expected %b", got.is_last, want.is_last));
    if (got.ovf !== want.ovf)
      report_mismatch($sformatf("overflowed %b, expected %b", got.ovf, want.ovf));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (sorted_i.valid && sorted_i.ready)
        compare_sorted({sorted_i.sorted_value, sorted_i.sorted_last, sorted_i.overflowed});
      if (elem_i.valid && elem_i.ready)
        load_element(elem_i.elem_value, elem_i.elem_last);
      expected_left_o = sorted_expect_q.size();
    end
  end

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// top of the quicksort engine testbench: clock, reset, element stimulus and verdict
`default_nettype none

module tb_top;
  import qs_pkg::*;

  typedef logic signed [ValW-1:0] elem_q_t[$];

  // generous bound for the whole run, full sets in ascending order included
  localparam int CycleLimit  = 1_000_000;
  localparam int DrainCycles = 20;
  localparam int PhaseElems  = 55;

  localparam logic signed [ValW-1:0] MinVal = {1'b1, {(ValW-1){1'b0}}};
  localparam logic signed [ValW-1:0] MaxVal = {1'b0, {(ValW-1){1'b1}}};

  logic clk_i;
  logic rst_ni;

  qs_in_if  elem_if();
  qs_out_if sorted_if();

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int cycle_count    = 0;
  int sets_sent      = 0;
  int elems_sent     = 0;
  int fail_count;
  int expected_left;
  int checked_beats;

  quicksort_engine u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .elem_i   (elem_if.sink),
    .sorted_o (sorted_if.source)
  );

  sort_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .elem_i          (elem_if),
    .sorted_i        (sorted_if),
    .fail_count_o    (fail_count),
    .expected_left_o (expected_left),
    .checked_o       (checked_beats)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // result side back-pressure, redrawn every cycle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sorted_if.ready <= 1'b0;
    end else begin
      sorted_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // hang guard
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d sorted beats outstanding",
               cycle_count, expected_left);
      $display("TB_ERROR");
      $finish;
    end
  end

  // one element beat; valid stays high into the next call unless that call idles
  task automatic send_beat(input logic signed [ValW-1:0] v, input logic is_last);
    while ($urandom_range(99) < send_idle_pct) begin
      elem_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    elem_if.valid      <= 1'b1;
    elem_if.elem_value <= v;
    elem_if.elem_last  <= is_last;
    @(posedge clk_i);
    while (!elem_if.ready) @(posedge clk_i);
    elems_sent++;
  endtask

  task automatic send_set(input elem_q_t vals);
    foreach (vals[i]) send_beat(vals[i], i == vals.size() - 1);
    sets_sent++;
  endtask

  // sender holds off until every sorted beat owed so far has been taken
  task automatic hold_until_drained();
    elem_if.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_left != 0) @(posedge clk_i);
  endtask

  // random content in one of four flavors:
  // full-range words, a narrow band full of duplicates, the extremes with zero and -1,
  // and a run counting up by one from a random base, the slow case for a first-element pivot
  function automatic elem_q_t build_set(input int count);
    elem_q_t                vals;
    int                     flavor;
    logic signed [ValW-1:0] base;
    flavor = $urandom_range(3);
    base   = $urandom;
    for (int i = 0; i < count; i++) begin
      case (flavor)
        0: vals.push_back($urandom);
        1: vals.push_back($signed($urandom_range(8)) - 4);
        2: begin
          case ($urandom_range(3))
            0: vals.push_back(MinVal);
            1: vals.push_back(MaxVal);
            2: vals.push_back('0);
            default: vals.push_back('1);
          endcase
        end
        default: vals.push_back(base + i);
      endcase
    end
    return vals;
  endfunction

  initial begin
    elem_q_t vals;
    int      phase_elems;
    int      count;

    rst_ni             <= 1'b0;
    elem_if.valid      <= 1'b0;
    elem_if.elem_value <= '0;
    elem_if.elem_last  <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed sets: single elements at both extremes, a reversed pair,
    // ordered and reverse-ordered runs across the full range, duplicates
    vals = {MaxVal};
    send_set(vals);
    vals = {MinVal};
    send_set(vals);
    vals = {MaxVal, MinVal};
    send_set(vals);
    vals = {MinVal, -32'sd1, 32'sd0, 32'sd1, MaxVal};
    send_set(vals);
    vals = {MaxVal, 32'sd1, 32'sd0, -32'sd1, MinVal};
    send_set(vals);
    vals = {32'sd3, 32'sd3, 32'sd3, -32'sd3, 32'sd3};
    send_set(vals);
    vals = {32'sd7, 32'sd7, 32'sd7, 32'sd7};
    send_set(vals);
    hold_until_drained();

    // random sets under four flow-control mixes; phase 1 opens with a set that
    // exactly fills the store, phase 3 with one that overflows it so that the
    // beat marked last is itself dropped
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 75;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 75;
        end
        default: begin
          send_idle_pct  = 29;
          recv_stall_pct = 29;
        end
      endcase
      phase_elems = 0;
      while (phase_elems < PhaseElems) begin
        if (phase_elems == 0 && phase == 1) begin
          count = MaxElems;
        end else if (phase_elems == 0 && phase == 3) begin
          count = MaxElems + 3;
        end else if ($urandom_range(99) < 5) begin
          count = $urandom_range(MaxElems + 6, MaxElems - 4);
        end else begin
          count = $urandom_range(12, 1);
        end
        vals = build_set(count);
        send_set(vals);
        phase_elems += count;
      end
      hold_until_drained();
    end

    // let any stray beat show up before the verdict
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d sets of 1 to %0d elements (%0d element beats), %0d sorted beats",
             sets_sent, MaxElems + 6, elems_sent, checked_beats);
    $display("compared under free flow, sender gaps, result stalls and both mixed");
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== quicksort_engine.f =====
rtl/qs_pkg.sv
rtl/qs_in_if.sv
rtl/qs_out_if.sv
rtl/qs_ram.sv
rtl/quicksort_engine.sv
test/sort_checker.sv
test/tb_top.sv
